// ===== rtl/core/psd_pkg.sv =====
package psd_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int FRAC_W          = 8;
	localparam int STD_W           = 16;
	localparam int RAD_W           = 2 * STD_W;
	localparam int MAX_SAMPLES_DEF = 1024;

	typedef struct packed {
		logic busy;
		logic done;
	} psd_unit_sts_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_MEAN,
		S_MEAN_WAIT,
		S_PASS,
		S_VAR,
		S_VAR_WAIT,
		S_ROOT,
		S_ROOT_WAIT,
		S_EMIT
	} psd_state_t;

endpackage

// ===== rtl/core/psd_in_if.sv =====
interface psd_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [psd_pkg::SAMPLE_W-1:0] sample;
	logic                              last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== rtl/core/psd_out_if.sv =====
interface psd_out_if #(
	parameter int CNT_W = $clog2(psd_pkg::MAX_SAMPLES_DEF + 1)
);
	logic                        valid;
	logic                        ready;
	logic [psd_pkg::STD_W-1:0]   std_dev;
	logic [CNT_W-1:0]            sample_count;
	logic                        overflowed;

	modport source (output valid, output std_dev, output sample_count, output overflowed,
		input ready);
	modport sink   (input valid, input std_dev, input sample_count, input overflowed,
		output ready);
endinterface

// ===== rtl/core/psd_ram.sv =====
module psd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/psd_div.sv =====
module psd_div #(
	parameter int DVD_W = 58,
	parameter int DVS_W = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DVD_W-1:0]       dividend,
	input  logic [DVS_W-1:0]       divisor,
	output psd_pkg::psd_unit_sts_t sts,
	output logic [DVD_W-1:0]       quotient,
	output logic                   rem_nz
);
	import psd_pkg::*;

	localparam int CW = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;
	assign rem_nz   = |rem_q;

endmodule

// ===== rtl/core/psd_sqrt.sv =====
module psd_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psd_pkg::RAD_W-1:0]     radicand,
	output psd_pkg::psd_unit_sts_t        sts,
	output logic [psd_pkg::STD_W-1:0]     root
);
	import psd_pkg::*;

	localparam int CW = $clog2(STD_W);

	logic [RAD_W-1:0] val_q;
	logic [STD_W:0]   rem_q;
	logic [STD_W-1:0] root_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [STD_W+1:0] trial_rem;
	logic [STD_W+1:0] trial_sub;
	logic [STD_W+1:0] diff;
	logic             ge;

	assign trial_rem = {rem_q[STD_W-1:0], val_q[RAD_W-1 -: 2]};
	assign trial_sub = {root_q, 2'b01};
	assign diff      = trial_rem - trial_sub;
	assign ge        = trial_rem >= trial_sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[STD_W:0] : trial_rem[STD_W:0];
			root_q <= {root_q[STD_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = root_q;

endmodule

// ===== rtl/core/population_std_deviation.sv =====
// Samples load at one transaction per cycle into the sample memory while the block is in its load state.
// After the last sample of a set the result is built by two runs of the bit-serial divider
// (mean and variance), a pass that reads each of the N stored samples, and a 16-step square root.
// No sample is taken from the last one until the result is in the output register.
// Reset (arst_n low) clears count, sum, overflow flag, state and output valid; memory is not cleared.
module population_std_deviation #(
	parameter int MAX_SAMPLES = psd_pkg::MAX_SAMPLES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	psd_in_if.sink    sample_ch,
	psd_out_if.source result_ch
);
	import psd_pkg::*;

	localparam int AW      = $clog2(MAX_SAMPLES);
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W   = SAMPLE_W + AW;
	localparam int MEAN_W  = SAMPLE_W + FRAC_W;
	localparam int DEV_W   = MEAN_W + 1;
	localparam int SQ_W    = 2 * (DEV_W - 1);
	localparam int ACC_W   = SQ_W + AW;
	localparam int VAR_SH  = 2 * FRAC_W;

	psd_state_t state_q, state_d;

	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     ovf_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [ACC_W-1:0]         acc_q;
	logic [CNT_W-1:0]         rd_idx_q;

	logic                     rd_v_s1;
	logic                     dev_v_s2;
	logic signed [DEV_W-1:0]  dev_s2;
	logic                     prod_v_s3;
	logic [SQ_W-1:0]          prod_s3;

	logic                     res_valid_q;
	logic [STD_W-1:0]         std_q;
	logic [CNT_W-1:0]         cnt_out_q;
	logic                     ovf_out_q;

	logic                     accept;
	logic                     full;
	logic                     wr_en;
	logic                     rd_issue;
	logic                     pass_done;
	logic                     div_start;
	logic                     sqrt_start;
	logic                     capture;
	logic                     out_free;

	logic [SAMPLE_W-1:0]      rd_data;
	logic signed [2*DEV_W-1:0] sq_full;
	logic                     sum_neg;
	logic [SUM_W-1:0]         sum_abs;
	logic [ACC_W-1:0]         div_dividend;
	psd_unit_sts_t            div_sts;
	logic [ACC_W-1:0]         div_quo;
	logic                     div_rem_nz;
	logic [MEAN_W-1:0]        mean_mag;
	psd_unit_sts_t            sqrt_sts;
	logic [STD_W-1:0]         sqrt_root;

	assign full     = count_q == CNT_W'(MAX_SAMPLES);
	assign accept   = sample_ch.valid && sample_ch.ready;
	assign wr_en    = accept && !full;
	assign out_free = !res_valid_q || result_ch.ready;
	assign rd_issue = (state_q == S_PASS) && (rd_idx_q != count_q);
	assign pass_done = (state_q == S_PASS) && (rd_idx_q == count_q)
		&& !rd_v_s1 && !dev_v_s2 && !prod_v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		sample_ch.ready  = 1'b0;
		div_start        = 1'b0;
		sqrt_start       = 1'b0;
		capture          = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				sample_ch.ready = 1'b1;
				if (sample_ch.valid && sample_ch.last_sample) begin
					state_d = S_MEAN;
				end
			end
			S_MEAN: begin
				div_start = 1'b1;
				state_d   = S_MEAN_WAIT;
			end
			S_MEAN_WAIT: begin
				if (div_sts.done) begin
					state_d = S_PASS;
				end
			end
			S_PASS: begin
				if (pass_done) begin
					state_d = S_VAR;
				end
			end
			S_VAR: begin
				div_start = 1'b1;
				state_d   = S_VAR_WAIT;
			end
			S_VAR_WAIT: begin
				if (div_sts.done) begin
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				sqrt_start = 1'b1;
				state_d    = S_ROOT_WAIT;
			end
			S_ROOT_WAIT: begin
				if (sqrt_sts.done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					capture = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (capture) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + {{(SUM_W - SAMPLE_W){sample_ch.sample[SAMPLE_W-1]}},
					sample_ch.sample};
			end
		end
	end

	psd_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (sample_ch.sample),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign sum_neg      = sum_q[SUM_W-1];
	assign sum_abs      = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_dividend = (state_q == S_MEAN)
		? {{(ACC_W - SUM_W - FRAC_W){1'b0}}, sum_abs, {FRAC_W{1'b0}}}
		: acc_q;

	psd_div #(
		.DVD_W (ACC_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (count_q),
		.sts      (div_sts),
		.quotient (div_quo),
		.rem_nz   (div_rem_nz)
	);

	// floor for a negative sum: round the magnitude up
	assign mean_mag = div_quo[MEAN_W-1:0] + MEAN_W'(sum_neg && div_rem_nz);

	always_ff @(posedge clk) begin
		if (state_q == S_MEAN_WAIT && div_sts.done) begin
			mean_q <= sum_neg ? -$signed(mean_mag) : $signed(mean_mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_v_s1   <= 1'b0;
			dev_v_s2  <= 1'b0;
			prod_v_s3 <= 1'b0;
		end else begin
			if (state_q == S_MEAN) begin
				rd_idx_q <= '0;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			rd_v_s1   <= rd_issue;
			dev_v_s2  <= rd_v_s1;
			prod_v_s3 <= dev_v_s2;
		end
	end

	assign sq_full = dev_s2 * dev_s2;

	always_ff @(posedge clk) begin
		dev_s2  <= $signed({{(DEV_W - SAMPLE_W - FRAC_W){rd_data[SAMPLE_W-1]}}, rd_data,
			{FRAC_W{1'b0}}}) - $signed({mean_q[MEAN_W-1], mean_q});
		prod_s3 <= sq_full[SQ_W-1:0];
		if (state_q == S_MEAN) begin
			acc_q <= '0;
		end else if (prod_v_s3) begin
			acc_q <= acc_q + {{(ACC_W - SQ_W){1'b0}}, prod_s3};
		end
	end

	psd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quo[VAR_SH +: RAD_W]),
		.sts      (sqrt_sts),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (capture) begin
			res_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			std_q     <= sqrt_root;
			cnt_out_q <= count_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign result_ch.valid        = res_valid_q;
	assign result_ch.std_dev      = std_q;
	assign result_ch.sample_count = cnt_out_q;
	assign result_ch.overflowed   = ovf_out_q;

`ifndef SYNTHESIS
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("stored count beyond capacity");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("divider restarted while busy");

	a_read_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (rd_idx_q < count_q))
		else $error("memory read beyond stored samples");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> (count_q == '0) && !ovf_q && result_ch.valid)
		else $error("set state not cleared after result");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> !wr_en)
		else $error("sample written during computation");
`endif

endmodule
